/* rtl/core/extended_gcd_macros.svh */
// Assertion macros for the extended GCD RTL.
`ifndef EXTENDED_GCD_MACROS_SVH
`define EXTENDED_GCD_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define EGCD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("extended_gcd: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define EGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("extended_gcd: next-cycle check failed");

`endif

/* rtl/core/egcd_pkg.sv */
// Package with widths, sequencer states and control structs of the extended GCD block.
`timescale 1ns / 1ps

package egcd_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int OPND_W      = DATA_WIDTH - 1;
    localparam int COEF_W      = 32;
    localparam int STEP_LIMIT  = 2 * DATA_WIDTH;
    localparam int STEP_W      = $clog2(STEP_LIMIT + 1);
    localparam int BIT_W       = $clog2(OPND_W);
    localparam int IN_BITS     = 2 * OPND_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = OPND_W + 2 * COEF_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPD,
        S_DONE
    } state_t;

    // Sequencer commands to the datapath
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic finish;
    } ctrl_t;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic small_zero;
    } stat_t;

endpackage

/* rtl/core/extended_gcd.sv */
// Top level of the extended GCD block: stream ports, sequencer and datapath.
`timescale 1ns / 1ps
`include "extended_gcd_macros.svh"

//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------
//  s_axis    | in        | first_value, second_value (31 b each)
//  m_axis    | out       | divisor (31 b), coeff_larger, coeff_smaller (32 b)
//
//  A request runs N Euclid steps (at most 44 for 31-bit operands, reached with
//  consecutive Fibonacci numbers), then returns to idle. A step is a check state,
//  a shift-subtract divide over the 31 dividend bits and a state to rotate values.
//  rst_n clears the sequencer and the output valid; payload registers are not reset.
//  s_axis_tready is high only when idle; a result waiting in the output register
//  lets one new request run, which then holds in its last state until m_axis_tready.

module extended_gcd
    import egcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [30:0] first_value, [61:31] second_value, [63:62] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [30:0] divisor, [62:31] coeff_larger, [94:63] coeff_smaller, [95] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    ctrl_t                    ctl;
    stat_t                    stat;
    logic [OPND_W-1:0]        first_value;
    logic [OPND_W-1:0]        second_value;
    logic [OPND_W-1:0]        divisor;
    logic signed [COEF_W-1:0] coeff_larger;
    logic signed [COEF_W-1:0] coeff_smaller;

    // unpack the request; padding bits are ignored
    assign first_value  = s_axis_tdata[OPND_W-1:0];
    assign second_value = s_axis_tdata[2*OPND_W-1:OPND_W];

    egcd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (stat),
        .ctl           (ctl)
    );

    egcd_datapath u_datapath (
        .clk           (clk),
        .first_value   (first_value),
        .second_value  (second_value),
        .ctl           (ctl),
        .stat          (stat),
        .divisor       (divisor),
        .coeff_larger  (coeff_larger),
        .coeff_smaller (coeff_smaller)
    );

    // pack the result, zero-fill to whole bytes
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                           coeff_smaller, coeff_larger, divisor};

    // accepting a request makes the block busy on the next cycle
    `EGCD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a quotient step is never taken with a zero divisor
    `EGCD_ASSERT_IMPLIES(a_update_nonzero, clk, rst_n, ctl.update, !stat.small_zero)
    // a zero divisor only comes from two zero operands: x = 1, y = 0
    `EGCD_ASSERT_IMPLIES(a_zero_gcd_coeffs, clk, rst_n, m_axis_tvalid && (divisor == '0), (coeff_larger == COEF_W'(1)) && (coeff_smaller == '0))
    // handing off a result frees the input side
    `EGCD_ASSERT_IMPLIES(a_ready_on_result, clk, rst_n, $rose(m_axis_tvalid), s_axis_tready)

endmodule

/* rtl/core/egcd_datapath.sv */
// Datapath of the extended GCD: operand registers, shared shift-subtract divider, coefficients.
`timescale 1ns / 1ps

module egcd_datapath
    import egcd_pkg::*;
(
    input  logic                     clk,
    input  logic [OPND_W-1:0]        first_value,
    input  logic [OPND_W-1:0]        second_value,
    input  ctrl_t                    ctl,
    output stat_t                    stat,
    output logic [OPND_W-1:0]        divisor,
    output logic signed [COEF_W-1:0] coeff_larger,
    output logic signed [COEF_W-1:0] coeff_smaller
);

    logic [OPND_W-1:0] big_reg, big_next;
    logic [OPND_W-1:0] small_reg, small_next;
    logic [OPND_W-1:0] rem_reg, rem_next;
    logic [OPND_W-1:0] dvd_reg, dvd_next;
    logic [COEF_W-1:0] cx_cur_reg, cx_cur_next, cy_cur_reg, cy_cur_next;
    logic [COEF_W-1:0] cx_nxt_reg, cx_nxt_next, cy_nxt_reg, cy_nxt_next;
    logic [COEF_W-1:0] acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic [OPND_W-1:0] res_div_reg, res_div_next;
    logic [COEF_W-1:0] res_cl_reg, res_cl_next, res_cs_reg, res_cs_next;

    logic [OPND_W:0]   trial;
    logic [OPND_W+1:0] diff;
    logic              qbit;

    // Shared restoring divide step: shift in the next dividend bit, try the subtract
    assign trial = {rem_reg, dvd_reg[OPND_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, small_reg};
    assign qbit  = ~diff[OPND_W+1];

    always_comb
    begin
        big_next     = big_reg;
        small_next   = small_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        cx_cur_next  = cx_cur_reg;
        cy_cur_next  = cy_cur_reg;
        cx_nxt_next  = cx_nxt_reg;
        cy_nxt_next  = cy_nxt_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        res_div_next = res_div_reg;
        res_cl_next  = res_cl_reg;
        res_cs_next  = res_cs_reg;

        if (ctl.load)
        begin
            // order operands, larger first
            if (second_value > first_value)
            begin
                big_next   = second_value;
                small_next = first_value;
            end
            else
            begin
                big_next   = first_value;
                small_next = second_value;
            end
            cx_cur_next = COEF_W'(1);
            cy_cur_next = '0;
            cx_nxt_next = '0;
            cy_nxt_next = COEF_W'(1);
        end

        if (ctl.div_init)
        begin
            rem_next   = '0;
            dvd_next   = big_reg;
            acc_x_next = '0;
            acc_y_next = '0;
        end

        if (ctl.div_step)
        begin
            rem_next   = qbit ? diff[OPND_W-1:0] : trial[OPND_W-1:0];
            dvd_next   = {dvd_reg[OPND_W-2:0], 1'b0};
            // build quotient * next coefficient MSB first
            acc_x_next = {acc_x_reg[COEF_W-2:0], 1'b0} + (qbit ? cx_nxt_reg : '0);
            acc_y_next = {acc_y_reg[COEF_W-2:0], 1'b0} + (qbit ? cy_nxt_reg : '0);
        end

        if (ctl.update)
        begin
            big_next    = small_reg;
            small_next  = rem_reg;
            cx_cur_next = cx_nxt_reg;
            cy_cur_next = cy_nxt_reg;
            cx_nxt_next = cx_cur_reg - acc_x_reg;
            cy_nxt_next = cy_cur_reg - acc_y_reg;
        end

        if (ctl.finish)
        begin
            res_div_next = big_reg;
            res_cl_next  = cx_cur_reg;
            res_cs_next  = cy_cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        big_reg     <= big_next;
        small_reg   <= small_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        cx_cur_reg  <= cx_cur_next;
        cy_cur_reg  <= cy_cur_next;
        cx_nxt_reg  <= cx_nxt_next;
        cy_nxt_reg  <= cy_nxt_next;
        acc_x_reg   <= acc_x_next;
        acc_y_reg   <= acc_y_next;
        res_div_reg <= res_div_next;
        res_cl_reg  <= res_cl_next;
        res_cs_reg  <= res_cs_next;
    end

    assign stat.small_zero = (small_reg == '0);
    assign divisor         = res_div_reg;
    assign coeff_larger    = res_cl_reg;
    assign coeff_smaller   = res_cs_reg;

endmodule

/* rtl/core/egcd_ctrl.sv */
// Sequencer of the extended GCD: step and bit counters, handshakes, output valid.
`timescale 1ns / 1ps

module egcd_ctrl
    import egcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_axis_tvalid,
    output logic  s_axis_tready,
    output logic  m_axis_tvalid,
    input  logic  m_axis_tready,
    input  stat_t stat,
    output ctrl_t ctl
);

    state_t            state_reg, state_next;
    logic [BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [STEP_W-1:0] step_cnt_reg, step_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              stop;
    logic              out_free;
    logic              last_bit;

    assign stop     = stat.small_zero || (step_cnt_reg == STEP_W'(STEP_LIMIT));
    assign out_free = !out_valid_reg || m_axis_tready;
    assign last_bit = (bit_cnt_reg == BIT_W'(OPND_W - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stop ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                if (last_bit)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                state_next = S_CHECK;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        ctl           = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                ctl.load      = s_axis_tvalid;
            end
            S_CHECK:
            begin
                ctl.div_init = !stop;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
            end
            S_UPD:
            begin
                ctl.update = 1'b1;
            end
            S_DONE:
            begin
                ctl.finish = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        bit_cnt_next   = bit_cnt_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg;
        if (ctl.div_init)
        begin
            bit_cnt_next = '0;
        end
        else if (ctl.div_step)
        begin
            bit_cnt_next = bit_cnt_reg + BIT_W'(1);
        end
        if (ctl.load)
        begin
            step_cnt_next = '0;
        end
        else if (ctl.update)
        begin
            step_cnt_next = step_cnt_reg + STEP_W'(1);
        end
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_cnt_reg   <= '0;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;

endmodule
